// ===== rtl/psd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psd_pkg: shared constants for the polyline segment densifier
// Field widths and derived datapath widths.
// ----------------------------------------------------------------------------
package psd_pkg;
  localparam int COORD_BITS  = 24;
  localparam int STEP_BITS   = 23;
  localparam int MAX_INSERT  = 63;
  localparam int STEP_RESET  = 1280;
  localparam int MAG_W       = COORD_BITS;
  localparam int DIFF_W      = COORD_BITS + 1;
  localparam int SQ_W        = 2 * MAG_W + 2;
  localparam int ROOT_W      = SQ_W / 2;
  localparam int REM_W       = ROOT_W + 3;
  localparam int DIVD_W      = MAG_W + STEP_BITS;
  localparam int K_W         = $clog2(MAX_INSERT + 1);
  localparam int NUM_W       = STEP_BITS + K_W + 1;
  localparam int RCNT_W      = $clog2(ROOT_W + 1);
  localparam int DCNT_W      = $clog2(DIVD_W + 1);
endpackage
`default_nettype wire

// ===== rtl/psd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psd_if: waypoint and result channels
// Valid/ready channels carrying one item each.
// ----------------------------------------------------------------------------
interface psd_in_if;
  import psd_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] x_coord;
  logic signed [COORD_BITS-1:0] y_coord;
  logic                         path_start;
  modport source (output valid, x_coord, y_coord, path_start, input ready);
  modport sink   (input valid, x_coord, y_coord, path_start, output ready);
endinterface

interface psd_out_if;
  import psd_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] out_x;
  logic signed [COORD_BITS-1:0] out_y;
  logic                         interpolated;
  logic                         saturated;
  logic                         run_last;
  modport source (output valid, out_x, out_y, interpolated, saturated, run_last,
                  input ready);
  modport sink   (input valid, out_x, out_y, interpolated, saturated, run_last,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/psd_isqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psd_isqrt: bit-serial integer square root
// One root bit per cycle, two radicand bits shifted in each step.
// ----------------------------------------------------------------------------
module psd_isqrt (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [psd_pkg::SQ_W-1:0]  radicand,
  output logic      [psd_pkg::ROOT_W-1:0] root,
  output logic                           rem_nz,
  output logic                           done
);
  import psd_pkg::*;

  logic [SQ_W-1:0]   rad_r,  rad_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [REM_W-1:0]  rem_r,  rem_nxt;
  logic [RCNT_W-1:0] cnt_r;
  logic              busy_r, done_r;
  logic [REM_W-1:0]  rem_sh, test;

  always_comb begin
    rem_sh  = {rem_r[REM_W-3:0], rad_r[SQ_W-1 -: 2]};
    test    = REM_W'({root_r, 2'b01});
    rad_nxt = rad_r << 2;
    if (rem_sh >= test) begin
      rem_nxt  = rem_sh - test;
      root_nxt = {root_r[ROOT_W-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_sh;
      root_nxt = {root_r[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= RCNT_W'(ROOT_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == RCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      root_r <= '0;
      rem_r  <= '0;
    end else if (busy_r) begin
      rad_r  <= rad_nxt;
      root_r <= root_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign root   = root_r;
  assign rem_nz = (rem_r != '0);
  assign done   = done_r;
endmodule
`default_nettype wire

// ===== rtl/psd_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psd_div: bit-serial restoring divider
// One quotient bit per cycle; quotient and remainder held after done.
// ----------------------------------------------------------------------------
module psd_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [psd_pkg::DIVD_W-1:0]  dividend,
  input  wire logic [psd_pkg::ROOT_W-1:0]  divisor,
  output logic      [psd_pkg::MAG_W-1:0]   quot,
  output logic      [psd_pkg::ROOT_W-1:0]  rem,
  output logic                             done
);
  import psd_pkg::*;

  logic [DIVD_W-1:0] q_r, q_nxt;
  logic [ROOT_W:0]   r_r, r_nxt, r_sh;
  logic [DCNT_W-1:0] cnt_r;
  logic              busy_r, done_r;

  always_comb begin
    r_sh = {r_r[ROOT_W-1:0], q_r[DIVD_W-1]};
    if (r_sh >= {1'b0, divisor}) begin
      r_nxt = r_sh - {1'b0, divisor};
      q_nxt = {q_r[DIVD_W-2:0], 1'b1};
    end else begin
      r_nxt = r_sh;
      q_nxt = {q_r[DIVD_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_W'(DIVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= dividend;
      r_r <= '0;
    end else if (busy_r) begin
      q_r <= q_nxt;
      r_r <= r_nxt;
    end
  end

  assign quot = q_r[MAG_W-1:0];
  assign rem  = r_r[ROOT_W-1:0];
  assign done = done_r;
endmodule
`default_nettype wire

// ===== rtl/polyline_segment_densifier_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// polyline_segment_densifier_core: inserts evenly spaced points on long segments
// Square root and per-axis division are bit serial; points stepped by an
// exact quotient/remainder accumulator, one point per cycle while the sink is ready.
// ----------------------------------------------------------------------------
// Sequencing: a path start or a missing previous point goes straight to the
//   waypoint result; otherwise the squares, root and division run in turn, a
//   short segment skipping the division, and inserted points follow one per
//   cycle while the sink is ready, then the waypoint itself.
// Throughput: one waypoint at a time; the next is taken once its last result is registered.
// Reset (synchronous, rst_n low): no previous point, max_step = 1280.
module polyline_segment_densifier_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  psd_in_if.sink                          in_item,
  psd_out_if.source                       out_item,
  input  wire logic                       cfg_we,
  input  wire logic [psd_pkg::STEP_BITS-1:0] cfg_wdata
);
  import psd_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SQUARE = 6'b000010,
    ST_ROOT   = 6'b000100,
    ST_DIVIDE = 6'b001000,
    ST_EMIT   = 6'b010000,
    ST_LAST   = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [STEP_BITS-1:0] step_r;
  logic [COORD_BITS-1:0] prev_x_r, prev_y_r, cur_x_r, cur_y_r;
  logic                have_prev_r, sat_r;
  logic [MAG_W-1:0]    ux_r, uy_r;
  logic                negx_r, negy_r;
  logic [MAG_W:0]      accqx_r, accqy_r;
  logic [ROOT_W:0]     accrx_r, accry_r;
  logic [NUM_W-1:0]    num_r;
  logic [K_W-1:0]      k_r;
  logic                out_valid_r;
  logic [COORD_BITS-1:0] out_x_r, out_y_r;
  logic                out_interp_r, out_sat_r, out_last_r;

  logic                in_acc, slot_free;
  logic [DIFF_W-1:0]   dx, dy;
  logic [2*MAG_W-1:0]  sq_x, sq_y;
  logic [SQ_W-1:0]     radicand;
  logic                sqrt_start, sqrt_done, rem_nz;
  logic [ROOT_W-1:0]   seg_len;
  logic [STEP_BITS-1:0] m_eff;
  logic [NUM_W-1:0]    m_w, dist_w, num_nxt, cap_num;
  logic                first_fits, cap_fits, next_fits;
  logic                div_start, divx_done, divy_done;
  logic [DIVD_W-1:0]   prod_x, prod_y;
  logic [MAG_W-1:0]    qx, qy;
  logic [ROOT_W-1:0]   rx, ry;
  logic [ROOT_W:0]     sum_rx, sum_ry, accrx_nxt, accry_nxt;
  logic [MAG_W:0]      sum_qx, sum_qy, accqx_nxt, accqy_nxt;
  logic [DIFF_W-1:0]   pt_x, pt_y;

  assign in_acc    = in_item.valid && in_item.ready;
  assign slot_free = !out_valid_r || out_item.ready;
  assign in_item.ready = (state_r == ST_IDLE);

  assign dx = {in_item.x_coord[COORD_BITS-1], in_item.x_coord}
            - {prev_x_r[COORD_BITS-1], prev_x_r};
  assign dy = {in_item.y_coord[COORD_BITS-1], in_item.y_coord}
            - {prev_y_r[COORD_BITS-1], prev_y_r};

  assign sq_x       = ux_r * ux_r;
  assign sq_y       = uy_r * uy_r;
  assign radicand   = SQ_W'(sq_x) + SQ_W'(sq_y);
  assign sqrt_start = (state_r == ST_SQUARE);

  psd_isqrt u_isqrt (
    .clk, .rst_n, .start(sqrt_start), .radicand,
    .root(seg_len), .rem_nz, .done(sqrt_done)
  );

  assign m_eff   = (step_r == '0) ? STEP_BITS'(1) : step_r;
  assign m_w     = NUM_W'(m_eff);
  assign dist_w  = NUM_W'(seg_len);
  assign cap_num = m_w * NUM_W'(MAX_INSERT + 1);
  assign num_nxt = num_r + m_w;
  assign first_fits = (m_w < dist_w) || ((m_w == dist_w) && rem_nz);
  assign cap_fits   = (cap_num < dist_w) || ((cap_num == dist_w) && rem_nz);
  assign next_fits  = (num_nxt < dist_w) || ((num_nxt == dist_w) && rem_nz);

  assign prod_x    = ux_r * m_eff;
  assign prod_y    = uy_r * m_eff;
  assign div_start = (state_r == ST_ROOT) && sqrt_done && first_fits;

  psd_div u_div_x (
    .clk, .rst_n, .start(div_start), .dividend(prod_x), .divisor(seg_len),
    .quot(qx), .rem(rx), .done(divx_done)
  );

  psd_div u_div_y (
    .clk, .rst_n, .start(div_start), .dividend(prod_y), .divisor(seg_len),
    .quot(qy), .rem(ry), .done(divy_done)
  );

  always_comb begin
    sum_rx = accrx_r + {1'b0, rx};
    sum_qx = accqx_r + {1'b0, qx};
    sum_ry = accry_r + {1'b0, ry};
    sum_qy = accqy_r + {1'b0, qy};
    if (sum_rx >= {1'b0, seg_len}) begin
      accrx_nxt = sum_rx - {1'b0, seg_len};
      accqx_nxt = sum_qx + 1'b1;
    end else begin
      accrx_nxt = sum_rx;
      accqx_nxt = sum_qx;
    end
    if (sum_ry >= {1'b0, seg_len}) begin
      accry_nxt = sum_ry - {1'b0, seg_len};
      accqy_nxt = sum_qy + 1'b1;
    end else begin
      accry_nxt = sum_ry;
      accqy_nxt = sum_qy;
    end
    pt_x = negx_r ? ({prev_x_r[COORD_BITS-1], prev_x_r} - DIFF_W'(accqx_nxt))
                  : ({prev_x_r[COORD_BITS-1], prev_x_r} + DIFF_W'(accqx_nxt));
    pt_y = negy_r ? ({prev_y_r[COORD_BITS-1], prev_y_r} - DIFF_W'(accqy_nxt))
                  : ({prev_y_r[COORD_BITS-1], prev_y_r} + DIFF_W'(accqy_nxt));
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (have_prev_r && !in_item.path_start) ? ST_SQUARE : ST_LAST;
        end
      end
      ST_SQUARE: state_nxt = ST_ROOT;
      ST_ROOT: begin
        if (sqrt_done) begin
          state_nxt = first_fits ? ST_DIVIDE : ST_LAST;
        end
      end
      ST_DIVIDE: begin
        if (divx_done && divy_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free && ((k_r == K_W'(MAX_INSERT)) || !next_fits)) begin
          state_nxt = ST_LAST;
        end
      end
      ST_LAST: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= STEP_BITS'(STEP_RESET);
      have_prev_r <= 1'b0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        step_r <= cfg_wdata;
      end
      if (((state_r == ST_EMIT) || (state_r == ST_LAST)) && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_item.ready) begin
        out_valid_r <= 1'b0;
      end
      if ((state_r == ST_LAST) && slot_free) begin
        have_prev_r <= 1'b1;
        prev_x_r    <= cur_x_r;
        prev_y_r    <= cur_y_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_x_r <= in_item.x_coord;
      cur_y_r <= in_item.y_coord;
      negx_r  <= dx[DIFF_W-1];
      negy_r  <= dy[DIFF_W-1];
      ux_r    <= dx[DIFF_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
      uy_r    <= dy[DIFF_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
      sat_r   <= 1'b0;
    end
    if ((state_r == ST_ROOT) && sqrt_done) begin
      sat_r   <= first_fits && cap_fits;
      accqx_r <= '0;
      accqy_r <= '0;
      accrx_r <= {2'b00, seg_len[ROOT_W-1:1]};
      accry_r <= {2'b00, seg_len[ROOT_W-1:1]};
      num_r   <= m_w;
      k_r     <= K_W'(1);
    end
    if ((state_r == ST_EMIT) && slot_free) begin
      accqx_r      <= accqx_nxt;
      accqy_r      <= accqy_nxt;
      accrx_r      <= accrx_nxt;
      accry_r      <= accry_nxt;
      num_r        <= num_nxt;
      k_r          <= k_r + 1'b1;
      out_x_r      <= pt_x[COORD_BITS-1:0];
      out_y_r      <= pt_y[COORD_BITS-1:0];
      out_interp_r <= 1'b1;
      out_sat_r    <= sat_r;
      out_last_r   <= 1'b0;
    end
    if ((state_r == ST_LAST) && slot_free) begin
      out_x_r      <= cur_x_r;
      out_y_r      <= cur_y_r;
      out_interp_r <= 1'b0;
      out_sat_r    <= sat_r;
      out_last_r   <= 1'b1;
    end
  end

  assign out_item.valid        = out_valid_r;
  assign out_item.out_x        = out_x_r;
  assign out_item.out_y        = out_y_r;
  assign out_item.interpolated = out_interp_r;
  assign out_item.saturated    = out_sat_r;
  assign out_item.run_last     = out_last_r;
endmodule
`default_nettype wire

// ===== rtl/psd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psd_checker: port-level checks for the densifier core
// Output handshake, single-item intake and reset behavior.
// ----------------------------------------------------------------------------
module psd_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [psd_pkg::COORD_BITS-1:0] out_x,
  input wire logic [psd_pkg::COORD_BITS-1:0] out_y,
  input wire logic                          out_flags_last
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_x) && $stable(out_y)
                                && $stable(out_flags_last))
    else $error("result changed while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind polyline_segment_densifier_core psd_checker u_psd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_item.valid),
  .in_ready       (in_item.ready),
  .out_valid      (out_item.valid),
  .out_ready      (out_item.ready),
  .out_x          (out_item.out_x),
  .out_y          (out_item.out_y),
  .out_flags_last (out_item.run_last)
);
`default_nettype wire

// ===== dv/polyline_segment_densifier_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline_segment_densifier_core_test: waypoint densifier testbench
// Sends short directed paths and then random paths under several maximum
// step settings and handshake idling patterns. Every emitted point is
// checked against an in-bench exact-count resampling model or a typed-in result.
// ----------------------------------------------------------------------------
module polyline_segment_densifier_core_test;
  import psd_pkg::*;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   interp;
    logic   sat;
    logic   last;
  } point_t;

  typedef struct {
    coord_t x;
    coord_t y;
    logic   start;
    logic   typed;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [STEP_BITS-1:0] cfg_wdata = '0;

  psd_in_if  in_ch ();
  psd_out_if out_ch ();

  polyline_segment_densifier_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_ch),
    .out_item (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  point_t pending_pts[$];
  logic [STEP_BITS-1:0] step_len;
  coord_t last_x, last_y;
  logic   have_last;
  int     send_idle, recv_idle;
  int     n_errors, n_items, n_points, n_inserted, n_saturated;

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.x_coord    = '0;
    in_ch.y_coord    = '0;
    in_ch.path_start = 1'b0;
    out_ch.ready     = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v    -= root + bitv;
        root  = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic longint unsigned round_div(longint unsigned mag, longint unsigned num,
                                                longint unsigned den);
    return (mag * num + den / 2) / den;
  endfunction

  task automatic queue_point(point_t pt);
    pending_pts.insert(pending_pts.size(), pt);
  endtask

  // Appends the points a waypoint produces and advances the path state.
  task automatic predict_points(coord_t x, coord_t y, logic start);
    longint dx, dy, px, py, qx, qy;
    longint unsigned ux, uy, d2, step, q, seg_len, ox, oy;
    int n;
    logic sat;
    n   = 0;
    sat = 1'b0;
    if (have_last && !start) begin
      px   = last_x;
      py   = last_y;
      dx   = longint'(x) - px;
      dy   = longint'(y) - py;
      ux   = dx < 0 ? -dx : dx;
      uy   = dy < 0 ? -dy : dy;
      d2   = ux * ux + uy * uy;
      step = (step_len == 0) ? 1 : step_len;
      for (int k = 1; k <= MAX_INSERT + 1; k++) begin
        q = k * step;
        if (q * q < d2) n = k;
        else break;
      end
      if (n > MAX_INSERT) begin
        sat = 1'b1;
        n   = MAX_INSERT;
      end
      if (n > 0) begin
        seg_len = int_sqrt(d2);
        for (int k = 1; k <= n; k++) begin
          ox = round_div(ux, k * step, seg_len);
          oy = round_div(uy, k * step, seg_len);
          qx = dx < 0 ? px - longint'(ox) : px + longint'(ox);
          qy = dy < 0 ? py - longint'(oy) : py + longint'(oy);
          queue_point('{coord_t'(qx), coord_t'(qy), 1'b1, sat, 1'b0});
        end
      end
    end
    queue_point('{x, y, 1'b0, sat, 1'b1});
    if (sat) n_saturated++;
    n_inserted += n;
    last_x    = x;
    last_y    = y;
    have_last = 1'b1;
  endtask

  always @(posedge clk) begin
    point_t exp_pt;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_points++;
      if (pending_pts.size() == 0) begin
        $error("unexpected point x=%0d y=%0d", out_ch.out_x, out_ch.out_y);
        n_errors++;
      end else begin
        exp_pt = pending_pts.pop_front();
        if (out_ch.out_x !== exp_pt.x) begin
          $error("out_x expected %0d got %0d", exp_pt.x, out_ch.out_x);
          n_errors++;
        end
        if (out_ch.out_y !== exp_pt.y) begin
          $error("out_y expected %0d got %0d", exp_pt.y, out_ch.out_y);
          n_errors++;
        end
        if (out_ch.interpolated !== exp_pt.interp) begin
          $error("interpolated expected %0b got %0b", exp_pt.interp, out_ch.interpolated);
          n_errors++;
        end
        if (out_ch.saturated !== exp_pt.sat) begin
          $error("saturated expected %0b got %0b", exp_pt.sat, out_ch.saturated);
          n_errors++;
        end
        if (out_ch.run_last !== exp_pt.last) begin
          $error("run_last expected %0b got %0b", exp_pt.last, out_ch.run_last);
          n_errors++;
        end
      end
    end
  end

  task automatic send_waypoint(coord_t x, coord_t y, logic start, logic typed);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.x_coord    <= x;
    in_ch.y_coord    <= y;
    in_ch.path_start <= start;
    do @(posedge clk); while (!in_ch.ready);
    n_items++;
    if (typed) begin
      // single waypoint result, typed in directly
      have_last = 1'b1;
      last_x    = x;
      last_y    = y;
      queue_point('{x, y, 1'b0, 1'b0, 1'b1});
    end else begin
      predict_points(x, y, start);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    wait (pending_pts.size() == 0);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_step(logic [STEP_BITS-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    step_len   = v;
  endtask

  task automatic random_waypoint();
    int unsigned sel, span;
    coord_t x, y;
    sel = $urandom_range(99);
    if (sel < 10 || !have_last) begin
      x = coord_t'($urandom);
      y = coord_t'($urandom);
      send_waypoint(x, y, 1'($urandom_range(1)), 1'b0);
    end else begin
      span = (step_len == 0 ? 1 : step_len) * $urandom_range(1, 70);
      if (span > 4000000) span = 4000000;
      x = coord_t'(last_x + $signed($urandom_range(2 * span)) - $signed(span));
      y = coord_t'(last_y + $signed($urandom_range(2 * span)) - $signed(span));
      send_waypoint(x, y, (sel < 16), 1'b0);
    end
  endtask

  row_t directed[$] = '{
    '{24'sd0,        24'sd0,        1'b1, 1'b1},
    '{24'sd8388607,  24'sd8388607,  1'b0, 1'b0},
    '{-24'sd8388608, -24'sd8388608, 1'b0, 1'b0},
    '{-24'sd8388608, -24'sd8388608, 1'b0, 1'b1},
    '{-24'sd8387328, -24'sd8388608, 1'b0, 1'b1},
    '{-24'sd8386047, -24'sd8388608, 1'b0, 1'b0},
    '{24'sd0,        24'sd0,        1'b1, 1'b1},
    '{24'sd3000,     24'sd4000,     1'b0, 1'b0},
    '{24'sd0,        24'sd0,        1'b0, 1'b0},
    '{-24'sd3000,    24'sd4000,     1'b0, 1'b0},
    '{-24'sd1,       -24'sd1,       1'b1, 1'b1},
    '{24'sd8388607,  -24'sd8388608, 1'b0, 1'b0},
    '{24'sd100,      -24'sd100,     1'b1, 1'b1},
    '{24'sd100,      24'sd1180,     1'b0, 1'b1},
    '{24'sd100,      24'sd2461,     1'b0, 1'b0},
    '{24'sd2661,     24'sd2461,     1'b1, 1'b1}
  };

  logic [STEP_BITS-1:0] step_plan[6] = '{23'd1280, 23'd1, 23'd8388607, 23'd0, 23'd200, 23'd37};

  initial begin
    step_len   = STEP_RESET;
    have_last  = 1'b0;
    last_x     = '0;
    last_y     = '0;
    n_errors   = 0;
    n_items    = 0;
    n_points   = 0;
    n_inserted = 0;
    n_saturated = 0;
    send_idle  = 24;
    recv_idle  = 76;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i])
      send_waypoint(directed[i].x, directed[i].y, directed[i].start, directed[i].typed);

    for (int ph = 0; ph < 6; ph++) begin
      write_step(ph == 5 ? STEP_BITS'($urandom_range(1, 8388607)) : step_plan[ph]);
      if (ph < 2) begin
        send_idle = 24;
        recv_idle = 76;
      end else if (ph < 4) begin
        send_idle = 76;
        recv_idle = 24;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      send_waypoint(coord_t'($urandom), coord_t'($urandom), 1'b1, 1'b0);
      for (int i = 0; i < 22; i++) begin
        if (ph == 1 && i == 10) begin
          in_ch.valid <= 1'b0;
          wait (pending_pts.size() == 0);
          @(posedge clk);
        end
        random_waypoint();
      end
    end

    drain();
    $display("covered %0d waypoints, %0d points (%0d inserted), %0d capped segments",
             n_items, n_points, n_inserted, n_saturated);
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("end of test: mismatches");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/psd_pkg.sv
rtl/psd_if.sv
rtl/psd_isqrt.sv
rtl/psd_div.sv
rtl/polyline_segment_densifier_core.sv
rtl/psd_checker.sv
dv/polyline_segment_densifier_core_test.sv
